// File: design/block_match_sad_best_vector_assert.svh
// Assertion macros shared by the block matching modules.
`ifndef BLOCK_MATCH_SAD_BEST_VECTOR_ASSERT_SVH
`define BLOCK_MATCH_SAD_BEST_VECTOR_ASSERT_SVH

`ifndef ASSERT_OFF
// Property checked on every clock edge outside reset; clk and rst_n come from the module.
`define BMSAD_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: assertion failed")
// Condition that must never hold outside reset.
`define BMSAD_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("%m: forbidden condition seen")
`else
`define BMSAD_ASSERT(label, prop)
`define BMSAD_NEVER(label, cond)
`endif

`endif

// File: design/bmsad_pkg.sv
// Types and constants shared by the block matching SAD modules.
package bmsad_pkg;

    localparam int PIX_W    = 8;
    localparam int OFS_W    = 8;
    localparam int IDX_W    = 10;
    localparam int SAD_W    = 20;
    localparam int LEN_W    = 16;
    localparam int SQ_W     = 15;

    // Candidates with an index at or above this never become the kept one
    localparam int MAX_CANDIDATES = 1024;

    // Marker values for a block that ended with no kept candidate
    localparam logic [SAD_W-1:0] SAD_NONE = '1;
    localparam logic [IDX_W-1:0] IDX_NONE = '1;

    // Item as it sits in the queue between front and back
    typedef struct packed {
        logic [PIX_W-1:0]        diff;
        logic signed [OFS_W-1:0] dx;
        logic signed [OFS_W-1:0] dy;
        logic [IDX_W-1:0]        index;
        logic [LEN_W-1:0]        len;
        logic                    last_pixel;
        logic                    last_cand;
    } item_t;

endpackage

// File: design/bmsad_front.sv
// Front end: accepts pixel pairs, forms |cur - ref| and the squared offsets.
module bmsad_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           cur_pixel,
    input  logic [7:0]           ref_pixel,
    input  logic signed [7:0]    cand_dx,
    input  logic signed [7:0]    cand_dy,
    input  logic [9:0]           cand_index,
    input  logic                 last_pixel,
    input  logic                 last_cand,
    output logic                 q_valid,
    input  logic                 q_ready,
    output bmsad_pkg::item_t     q_item
);
    import bmsad_pkg::*;

    typedef struct packed {
        logic [PIX_W-1:0]        diff;
        logic signed [OFS_W-1:0] dx;
        logic signed [OFS_W-1:0] dy;
        logic [IDX_W-1:0]        index;
        logic [SQ_W-1:0]         dx_sq;
        logic [SQ_W-1:0]         dy_sq;
        logic                    last_pixel;
        logic                    last_cand;
    } stage_t;

    logic                         valid_reg;
    logic                         valid_next;
    stage_t                       stage_reg;
    stage_t                       stage_next;
    logic signed [2*OFS_W-1:0]    dx_prod;
    logic signed [2*OFS_W-1:0]    dy_prod;
    logic                         load;

    // Stage register frees when its item moves into the queue
    assign in_ready = !valid_reg || q_ready;
    assign load     = in_valid && in_ready;

    // Absolute difference and squares of the offsets
    always_comb
    begin
        dx_prod = cand_dx * cand_dx;
        dy_prod = cand_dy * cand_dy;
        stage_next.diff       = (cur_pixel > ref_pixel) ? cur_pixel - ref_pixel
                                                        : ref_pixel - cur_pixel;
        stage_next.dx         = cand_dx;
        stage_next.dy         = cand_dy;
        stage_next.index      = cand_index;
        stage_next.dx_sq      = SQ_W'(dx_prod);
        stage_next.dy_sq      = SQ_W'(dy_prod);
        stage_next.last_pixel = last_pixel;
        stage_next.last_cand  = last_cand;
    end

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (q_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            stage_reg <= stage_next;
        end
    end

    // Queue entry: vector length summed after the register
    always_comb
    begin
        q_valid           = valid_reg;
        q_item.diff       = stage_reg.diff;
        q_item.dx         = stage_reg.dx;
        q_item.dy         = stage_reg.dy;
        q_item.index      = stage_reg.index;
        q_item.len        = LEN_W'(stage_reg.dx_sq) + LEN_W'(stage_reg.dy_sq);
        q_item.last_pixel = stage_reg.last_pixel;
        q_item.last_cand  = stage_reg.last_cand;
    end

endmodule

// File: design/bmsad_queue.sv
// Short flip-flop queue that decouples the front end from the back end.
`include "block_match_sad_best_vector_assert.svh"

module bmsad_queue #(
    parameter int DEPTH = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  bmsad_pkg::item_t     push_item,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output bmsad_pkg::item_t     pop_item
);
    import bmsad_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t              mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer wrap and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    `BMSAD_ASSERT(a_count_bound, count_reg <= CNT_W'(DEPTH));
    `BMSAD_NEVER(a_ptr_mismatch, count_reg == '0 && wr_ptr_reg != rd_ptr_reg);

endmodule

// File: design/bmsad_back.sv
// Back end: SAD accumulation per candidate, best-candidate selection, result register.
`include "block_match_sad_best_vector_assert.svh"

module bmsad_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  bmsad_pkg::item_t     q_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [7:0]    best_dx,
    output logic signed [7:0]    best_dy,
    output logic [19:0]          best_sad,
    output logic [9:0]           best_index
);
    import bmsad_pkg::*;

    // Closed candidate handed from accumulation to selection
    typedef struct packed {
        logic [SAD_W-1:0]        sad;
        logic signed [OFS_W-1:0] dx;
        logic signed [OFS_W-1:0] dy;
        logic [IDX_W-1:0]        index;
        logic [LEN_W-1:0]        len;
        logic                    last_cand;
    } close_t;

    logic [SAD_W-1:0]        acc_reg;
    logic [SAD_W-1:0]        acc_next;
    logic [SAD_W:0]          acc_sum;
    logic [SAD_W-1:0]        acc_sat;
    logic                    close_valid_reg;
    logic                    close_valid_next;
    close_t                  close_reg;
    logic                    close_take;
    logic                    close_free;
    logic                    close_load;
    logic                    pop;

    logic                    have_reg;
    logic                    have_next;
    logic [SAD_W-1:0]        kept_sad_reg;
    logic [SAD_W-1:0]        kept_sad_next;
    logic signed [OFS_W-1:0] kept_dx_reg;
    logic signed [OFS_W-1:0] kept_dx_next;
    logic signed [OFS_W-1:0] kept_dy_reg;
    logic signed [OFS_W-1:0] kept_dy_next;
    logic [IDX_W-1:0]        kept_index_reg;
    logic [IDX_W-1:0]        kept_index_next;
    logic [LEN_W-1:0]        kept_len_reg;
    logic [LEN_W-1:0]        kept_len_next;
    logic                    index_ok;
    logic                    take;
    logic                    emit;

    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic signed [OFS_W-1:0] out_dx_reg;
    logic signed [OFS_W-1:0] out_dy_reg;
    logic [SAD_W-1:0]        out_sad_reg;
    logic [IDX_W-1:0]        out_index_reg;

    // Handshake chain: output slot -> selection stage -> accumulator pop
    assign emit       = close_valid_reg && close_reg.last_cand;
    assign close_take = close_valid_reg && (!close_reg.last_cand || !out_valid_reg || out_ready);
    assign close_free = !close_valid_reg || close_take;
    assign pop        = q_valid && (!q_item.last_pixel || close_free);
    assign q_ready    = !q_item.last_pixel || close_free;
    assign close_load = pop && q_item.last_pixel;

    // Saturating accumulate of one absolute difference
    always_comb
    begin
        acc_sum = {1'b0, acc_reg} + (SAD_W + 1)'(q_item.diff);
        acc_sat = acc_sum[SAD_W] ? SAD_NONE : acc_sum[SAD_W-1:0];
        if (pop)
        begin
            acc_next = q_item.last_pixel ? '0 : acc_sat;
        end
        else
        begin
            acc_next = acc_reg;
        end
    end

    always_comb
    begin
        if (close_load)
        begin
            close_valid_next = 1'b1;
        end
        else if (close_take)
        begin
            close_valid_next = 1'b0;
        end
        else
        begin
            close_valid_next = close_valid_reg;
        end
    end

    // Preference: lower SAD, then shorter vector, then lower or equal index
    always_comb
    begin
        index_ok = (32'(close_reg.index) < 32'(MAX_CANDIDATES));
        priority if (!have_reg)
        begin
            take = 1'b1;
        end
        else if (close_reg.sad != kept_sad_reg)
        begin
            take = (close_reg.sad < kept_sad_reg);
        end
        else if (close_reg.len != kept_len_reg)
        begin
            take = (close_reg.len < kept_len_reg);
        end
        else
        begin
            take = (close_reg.index <= kept_index_reg);
        end
    end

    // Kept candidate after this close, before the end-of-block clear
    always_comb
    begin
        have_next       = have_reg;
        kept_sad_next   = kept_sad_reg;
        kept_dx_next    = kept_dx_reg;
        kept_dy_next    = kept_dy_reg;
        kept_index_next = kept_index_reg;
        kept_len_next   = kept_len_reg;
        if (close_take && index_ok && take)
        begin
            have_next       = 1'b1;
            kept_sad_next   = close_reg.sad;
            kept_dx_next    = close_reg.dx;
            kept_dy_next    = close_reg.dy;
            kept_index_next = close_reg.index;
            kept_len_next   = close_reg.len;
        end
    end

    always_comb
    begin
        if (close_take && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg         <= '0;
            close_valid_reg <= 1'b0;
            have_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            acc_reg         <= acc_next;
            close_valid_reg <= close_valid_next;
            have_reg        <= (close_take && emit) ? 1'b0 : have_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (close_load)
        begin
            close_reg.sad       <= acc_sat;
            close_reg.dx        <= q_item.dx;
            close_reg.dy        <= q_item.dy;
            close_reg.index     <= q_item.index;
            close_reg.len       <= q_item.len;
            close_reg.last_cand <= q_item.last_cand;
        end
    end

    // Kept values; they only count while have_reg is set
    always_ff @(posedge clk)
    begin
        kept_sad_reg   <= kept_sad_next;
        kept_dx_reg    <= kept_dx_next;
        kept_dy_reg    <= kept_dy_next;
        kept_index_reg <= kept_index_next;
        kept_len_reg   <= kept_len_next;
    end

    // Result register, loaded at the end of a block
    always_ff @(posedge clk)
    begin
        if (close_take && emit)
        begin
            if (have_next)
            begin
                out_dx_reg    <= kept_dx_next;
                out_dy_reg    <= kept_dy_next;
                out_sad_reg   <= kept_sad_next;
                out_index_reg <= kept_index_next;
            end
            else
            begin
                out_dx_reg    <= '0;
                out_dy_reg    <= '0;
                out_sad_reg   <= SAD_NONE;
                out_index_reg <= IDX_NONE;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign best_dx    = out_dx_reg;
    assign best_dy    = out_dy_reg;
    assign best_sad   = out_sad_reg;
    assign best_index = out_index_reg;

    `BMSAD_ASSERT(a_acc_clears, pop && q_item.last_pixel |=> acc_reg == '0);
    `BMSAD_ASSERT(a_block_restart, close_take && emit |=> !have_reg && out_valid_reg);
    `BMSAD_ASSERT(a_close_holds, close_valid_reg && !close_take |=> close_valid_reg && $stable(close_reg));

endmodule

// File: design/block_match_sad_best_vector.sv
// Top level of the block matching SAD best-vector search.
//
// Streams current/reference pixel pairs of one current block, grouped by
// candidate (tlast closes a candidate, tuser closes the block together with
// tlast), and returns one result item per block: the best vector, its SAD
// and its window index. One pair is accepted every clock cycle, sustained,
// while the output is not held up. A pair passes the front register, the
// queue and the close register in that order, and the result register
// loads at the end of a block; the result is offered once it has loaded.
// The queue of QUEUE_DEPTH items absorbs output stalls; an unread result
// only holds up input once the next block closes and the queue has filled.
module block_match_sad_best_vector #(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // cur_pixel[7:0], ref_pixel[15:8], cand_dx[23:16], cand_dy[31:24],
    // cand_index[41:32], zero fill [47:42]
    input  logic [47:0] s_axis_tdata,
    input  logic        s_axis_tlast,   // last_pixel
    input  logic        s_axis_tuser,   // last_cand
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // best_dx[7:0], best_dy[15:8], best_sad[35:16], best_index[45:36],
    // zero fill [47:46]
    output logic [47:0] m_axis_tdata
);
    import bmsad_pkg::*;

    logic                    fq_valid;
    logic                    fq_ready;
    item_t                   fq_item;
    logic                    qb_valid;
    logic                    qb_ready;
    item_t                   qb_item;
    logic signed [OFS_W-1:0] best_dx;
    logic signed [OFS_W-1:0] best_dy;
    logic [SAD_W-1:0]        best_sad;
    logic [IDX_W-1:0]        best_index;

    bmsad_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .cur_pixel  (s_axis_tdata[7:0]),
        .ref_pixel  (s_axis_tdata[15:8]),
        .cand_dx    (s_axis_tdata[23:16]),
        .cand_dy    (s_axis_tdata[31:24]),
        .cand_index (s_axis_tdata[41:32]),
        .last_pixel (s_axis_tlast),
        .last_cand  (s_axis_tuser),
        .q_valid    (fq_valid),
        .q_ready    (fq_ready),
        .q_item     (fq_item)
    );

    bmsad_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_item  (fq_item),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_item   (qb_item)
    );

    bmsad_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (qb_valid),
        .q_ready    (qb_ready),
        .q_item     (qb_item),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .best_dx    (best_dx),
        .best_dy    (best_dy),
        .best_sad   (best_sad),
        .best_index (best_index)
    );

    // Result item packing, lowest field first
    assign m_axis_tdata = {2'b00, best_index, best_sad, best_dy, best_dx};

endmodule
